FILE: rtl/core/cbt_pkg.sv
package cbt_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_MARK  = 2'd1,
        FUNC_FIND  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_DONE
    } state_t;

    // register index as decoded from paddr[2]
    localparam logic REG_CHUNK_COUNT = 1'b0;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_MSB  = 8'h80;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] chunk_index;
        logic        set_value;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [11:0] missing_index;
    } res_t;

endpackage

FILE: rtl/core/chunk_bitmap_tracker.sv
// channel   dir  tdata (low bit up)                        tuser
// s_*       in   chunk_index[11:0], set_value[12], pad     func[1:0]
// m_*       out  missing_index[11:0], pad                  found
// apb       in   reg 0 chunk_count at byte address 0
//
// One item at a time. A mark reads its bitmap byte and writes it back, a find reads
// byte after byte (one bitmap read per cycle) until one is not all ones or the used bytes
// run out, a clear writes every byte (one write per cycle through the single write port),
// and anything else goes straight to DONE; s_tready comes back in the same cycle as m_tvalid.
// After reset a clearing pass writes all DEPTH bytes (512 by default) with
// s_tready low. A result waiting on m_tready holds the next one in DONE.
module chunk_bitmap_tracker #(
    parameter int MAX_CHUNKS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // chunk_index[11:0], set_value[12], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // missing_index[11:0], zero pad
    output logic        m_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbt_pkg::*;

    localparam int DEPTH = (MAX_CHUNKS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [12:0]    chunk_count;
    cmd_t           cmd;
    res_t           res;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign cmd.func        = s_tuser;
    assign cmd.chunk_index = s_tdata[11:0];
    assign cmd.set_value   = s_tdata[12];

    cbt_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .chunk_count (chunk_count)
    );

    cbt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cbt_ctrl #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .chunk_count (chunk_count),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_cmd       (cmd),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_res       (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    assign m_tdata = {4'd0, res.missing_index};
    assign m_tuser = res.found;
endmodule

FILE: rtl/core/cbt_ram.sv
module cbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/cbt_regs.sv
module cbt_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [12:0] chunk_count
);
    import cbt_pkg::*;

    logic [12:0] chunk_count_reg;
    logic [12:0] chunk_count_next;
    logic        hit;

    assign hit = (paddr[2] == REG_CHUNK_COUNT);

    always_comb begin
        chunk_count_next = chunk_count_reg;
        if (psel && penable && pwrite && hit) begin
            chunk_count_next = pwdata[12:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_count_reg <= '0;
        end else begin
            chunk_count_reg <= chunk_count_next;
        end
    end

    assign prdata      = hit ? {19'd0, chunk_count_reg} : 32'd0;
    assign pready      = 1'b1;
    assign chunk_count = chunk_count_reg;
endmodule

FILE: rtl/core/cbt_ctrl.sv
module cbt_ctrl #(
    parameter int MAX_CHUNKS = 4096,
    parameter int DEPTH      = 512,
    parameter int AW         = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [12:0]       chunk_count,
    input  logic              s_valid,
    output logic              s_ready,
    input  cbt_pkg::cmd_t     s_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output cbt_pkg::res_t     m_res,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [7:0]        ram_rdata
);
    import cbt_pkg::*;

    localparam int MW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = (MW > 13) ? MW : 13;
    localparam int BW = AW + 1;
    localparam int CW = (BW + 3 > EW) ? BW + 3 : EW;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    res_t            res_reg, res_next;
    res_t            out_reg, out_next;
    logic            m_valid_reg, m_valid_next;
    logic [BW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   clr_reg, clr_next;

    logic [EW-1:0]   eff;
    logic [BW-1:0]   bytes_used;
    logic [BW-1:0]   cur_inc;
    logic            in_range;
    logic [2:0]      pos;
    logic [CW-1:0]   cand;
    logic [7:0]      mask;

    // counts above capacity act as capacity
    assign eff = (EW'(chunk_count) > EW'(MAX_CHUNKS)) ? EW'(MAX_CHUNKS) : EW'(chunk_count);
    assign bytes_used = BW'(({1'b0, eff} + (EW + 1)'(7)) >> 3);
    assign in_range   = EW'(s_cmd.chunk_index) < eff;
    assign cur_inc    = cur_reg + BW'(1);
    assign mask       = BYTE_MSB >> cmd_reg.chunk_index[2:0];

    // first clear bit from the MSB side; lowest chunk index sits in bit 7
    always_comb begin
        logic hit;
        hit = 1'b0;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (!hit && !ram_rdata[7 - i]) begin
                pos = 3'(i);
                hit = 1'b1;
            end
        end
    end

    assign cand = CW'({cur_reg, pos});

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        cur_next     = cur_reg;
        clr_next     = clr_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg) inside
            ST_INIT, ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_cmd;
                    res_next = '0;
                    clr_next = '0;
                    cur_next = BW'(EW'(s_cmd.chunk_index) >> 3);
                    unique case (s_cmd.func)
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_MARK:  state_next = in_range ? ST_MARK_RD : ST_DONE;
                        FUNC_FIND:  state_next = in_range ? ST_FIND_RD : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_MARK_RD:  state_next = ST_MARK_WR;
            ST_MARK_WR:  state_next = ST_DONE;
            ST_FIND_RD:  state_next = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (ram_rdata == BYTE_ONES) begin
                    if (cur_inc < bytes_used) begin
                        cur_next = cur_inc;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    if (cand < CW'(eff)) begin
                        res_next.found         = 1'b1;
                        res_next.missing_index = 12'(cand);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 8'h00;
        // in the scan state the next byte is fetched ahead of the check
        ram_raddr = (state_reg == ST_FIND_CHK) ? AW'(cur_inc) : AW'(cur_reg);
        unique case (state_reg) inside
            ST_INIT, ST_CLEAR: ram_we = 1'b1;
            ST_MARK_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cur_reg);
                ram_wdata = cmd_reg.set_value ? (ram_rdata | mask) : (ram_rdata & ~mask);
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
        cur_reg <= cur_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;
endmodule

FILE: rtl/core/cbt_checker.sv
module cbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a result without a hit carries index zero
    a_nofind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
        else $error("nonzero index with found low");

    // one item in flight: ready drops after every accepted transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // clearing pass right after reset keeps the input closed
    a_init_closed: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input open during clearing pass");
endmodule

bind chunk_bitmap_tracker cbt_checker u_cbt_checker (.*);

FILE: verif/chunk_bitmap_checker.sv
module chunk_bitmap_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // chunk_index[11:0], set_value[12], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // missing_index[11:0], zero pad
    input  logic        m_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          n_results,
    output int          n_found
);
    import cbt_pkg::*;

    localparam int CHUNK_CAP   = 4096;
    localparam int STORE_BYTES = (CHUNK_CAP + 7) / 8;

    logic [7:0]  rx_bits [0:STORE_BYTES-1];
    logic [12:0] chunk_count_q;
    res_t        expected_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        n_results  = 0;
        n_found    = 0;
    end

    // Applies one command to the shadow bitmap and returns the result it owes.
    function automatic res_t predict_result(input logic [1:0] f, input logic [11:0] idx,
                                            input logic sv);
        int unsigned count;
        int unsigned nbytes;
        int unsigned b;
        int unsigned pos;
        int unsigned cand;
        logic [7:0]  mask;
        res_t        r;
        r     = '0;
        count = (chunk_count_q > 13'(CHUNK_CAP)) ? CHUNK_CAP : chunk_count_q;
        mask  = BYTE_MSB >> idx[2:0];
        case (f)
            FUNC_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++) rx_bits[i] = '0;
            end
            FUNC_MARK: begin
                if (idx < count) begin
                    if (sv) rx_bits[idx[11:3]] = rx_bits[idx[11:3]] | mask;
                    else    rx_bits[idx[11:3]] = rx_bits[idx[11:3]] & ~mask;
                end
            end
            FUNC_FIND: begin
                if (idx < count) begin
                    nbytes = (count + 7) >> 3;
                    b      = idx >> 3;
                    while (b < nbytes && rx_bits[b] == BYTE_ONES) b++;
                    // only the first byte that is not all ones is looked at
                    if (b < nbytes) begin
                        pos = 0;
                        while (pos < 8 && rx_bits[b][7-pos]) pos++;
                        cand = b * 8 + pos;
                        if (cand < count) begin
                            r.found         = 1'b1;
                            r.missing_index = cand[11:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %0d at result %0d: %s expected %0d got %0d",
                     fail_count, n_results, what, want_v, got_v);
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            for (int i = 0; i < STORE_BYTES; i++) rx_bits[i] = '0;
            chunk_count_q = '0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK_COUNT)
                chunk_count_q = pwdata[12:0];
            if (m_tvalid && m_tready) begin
                got.found         = m_tuser;
                got.missing_index = m_tdata[11:0];
                n_results <= n_results + 1;
                if (got.found === 1'b1) n_found <= n_found + 1;
                if (expected_q.size() == 0) begin
                    note_mismatch("result with nothing outstanding, index", 32'd0,
                                  32'(got.missing_index));
                end else begin
                    want = expected_q.pop_front();
                    if (got.found !== want.found)
                        note_mismatch("found", 32'(want.found), 32'(got.found));
                    if (got.missing_index !== want.missing_index)
                        note_mismatch("missing_index", 32'(want.missing_index),
                                      32'(got.missing_index));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_result(s_tuser, s_tdata[11:0], s_tdata[12]));
            pending <= expected_q.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import cbt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         N_SEGMENTS  = 8;
    localparam int         SEG_ITEMS   = 82;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int n_results;
    int n_found;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          n_sent         = 0;
    int          n_cfg          = 0;
    int          cycle_cnt      = 0;
    logic [12:0] cur_count      = '0;
    int          seg_counts [N_SEGMENTS] = '{4096, 37, 1, 64, 8191, 200, 15, 0};

    chunk_bitmap_tracker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    chunk_bitmap_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .n_results  (n_results),
        .n_found    (n_found)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("** chunk_bitmap_tracker: FAILED **");
            $finish;
        end
    end

    function automatic int eff_count();
        return (cur_count > 13'd4096) ? 4096 : int'(cur_count);
    endfunction

    // mostly inside the live range or just past it, now and then anywhere
    function automatic logic [11:0] pick_index();
        int lim;
        lim = eff_count() + 8;
        if (lim > 4096) lim = 4096;
        if ($urandom_range(99) < 15) return 12'($urandom);
        return 12'($urandom_range(0, lim - 1));
    endfunction

    // returns at the edge where the transfer happened, tvalid still high
    task automatic send_item(input logic [1:0] f, input logic [11:0] idx, input logic sv);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sv, idx};
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_chunk_count(input logic [12:0] v);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CHUNK_COUNT, 2'b00};
        pwdata  <= {19'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_count  = v;
        n_cfg++;
    endtask

    task automatic random_segment(input int n_items);
        int done_n;
        int pick;
        int start;
        int len;
        int lim;
        bit paused;
        done_n = 0;
        paused = 0;
        while (done_n < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // fill a run of chunks, then search from somewhere inside it or just past its end
                lim = eff_count();
                if (lim == 0) lim = 8;
                start = $urandom_range(0, lim - 1);
                len   = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) send_item(FUNC_MARK, 12'(start + i), 1'b1);
                send_item(FUNC_FIND, 12'(start + $urandom_range(0, len)), 1'($urandom));
                done_n += len + 1;
            end else begin
                if (pick < 11)
                    send_item(FUNC_CLEAR, 12'($urandom), 1'($urandom));
                else if (pick < 13)
                    send_item(FUNC_UNUSED, 12'($urandom), 1'($urandom));
                else if (pick < 45)
                    send_item(FUNC_FIND, pick_index(), 1'($urandom));
                else
                    send_item(FUNC_MARK, pick_index(), ($urandom_range(99) < 80));
                done_n++;
            end
            // once, halfway through, hold off until the block has answered everything
            if (!paused && done_n >= n_items / 2) begin
                drain_results();
                paused = 1;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // count 0 after reset: nothing is in range
        send_item(FUNC_FIND, 12'd0, 1'b0);
        send_item(FUNC_MARK, 12'd0, 1'b1);

        set_chunk_count(13'd10);
        send_item(FUNC_FIND, 12'd0, 1'b0);
        for (int i = 0; i < 8; i++) send_item(FUNC_MARK, 12'(i), 1'b1);
        send_item(FUNC_FIND, 12'd3, 1'b0);
        send_item(FUNC_MARK, 12'd8, 1'b1);
        send_item(FUNC_MARK, 12'd9, 1'b1);
        send_item(FUNC_FIND, 12'd0, 1'b1);      // first clear bit sits at the count
        send_item(FUNC_MARK, 12'd10, 1'b1);     // out of range, dropped
        send_item(FUNC_UNUSED, 12'hFFF, 1'b1);

        set_chunk_count(13'd8);                 // lowered: search runs off the end
        send_item(FUNC_FIND, 12'd2, 1'b0);

        set_chunk_count(13'd10);
        send_item(FUNC_MARK, 12'd3, 1'b0);
        send_item(FUNC_FIND, 12'd5, 1'b0);      // earlier bit of the start byte counts
        send_item(FUNC_FIND, 12'hFFF, 1'b0);
        send_item(FUNC_CLEAR, 12'd0, 1'b0);
        send_item(FUNC_FIND, 12'd0, 1'b0);

        set_chunk_count(13'h1FFF);              // above capacity, acts as full size
        send_item(FUNC_MARK, 12'hFFF, 1'b1);
        send_item(FUNC_FIND, 12'hFFF, 1'b0);

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            if (seg == N_SEGMENTS - 1) set_chunk_count(13'($urandom_range(1, 128)));
            else                       set_chunk_count(13'(seg_counts[seg]));
            random_segment(SEG_ITEMS);
        end

        drain_results();
        repeat (16) @(posedge aclk);

        $display("ran %0d commands under %0d chunk-count settings and four idle/stall mixes",
                 n_sent, n_cfg);
        $display("checked %0d results, %0d of them reporting a missing chunk",
                 n_results, n_found);
        if (fail_count == 0 && pending == 0) begin
            $display("** chunk_bitmap_tracker: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending);
            $display("** chunk_bitmap_tracker: FAILED **");
        end
        $finish;
    end

endmodule
